[rtl/core/time_offset_to_utc_unit_defines.svh]
// Assertion macros shared by the time offset to UTC unit.
`ifndef TIME_OFFSET_TO_UTC_UNIT_DEFINES_SVH
`define TIME_OFFSET_TO_UTC_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TOU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("time offset unit: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TOU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("time offset unit: next-cycle check failed");

`endif

[rtl/core/tou_pkg.sv]
// Types, constants and calendar helpers for the time offset to UTC unit.
`default_nettype none

package tou_pkg;

    localparam logic [13:0] YEAR_MOD_FOUR = 14'd10000;
    localparam logic [13:0] YEAR_TOP_FOUR = 14'd9999;
    localparam logic [13:0] YEAR_TOP_TWO  = 14'd99;

    // The quotient by 100 is taken as (y * 655) >> 16, which never overshoots for
    // 14-bit years and falls short by at most one.
    localparam logic [9:0]  RECIP_CENTURY = 10'd655;
    localparam int unsigned RECIP_SHIFT   = 16;
    localparam logic [6:0]  CENTURY       = 7'd100;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] DAYS_LONG   = 5'd31;
    localparam logic [4:0] DAYS_SHORT  = 5'd30;
    localparam logic [4:0] DAYS_FEB_LP = 5'd29;
    localparam logic [4:0] DAYS_FEB    = 5'd28;

    localparam logic [4:0] HOUR_MAX     = 5'd23;
    localparam logic [5:0] MINUTE_MAX   = 6'd59;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY = 6'd24;

    typedef struct packed {
        logic        two_digit_year;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        has_offset;
        logic        offset_negative;
        logic [4:0]  offset_hours;
        logic [5:0]  offset_minutes;
    } t_stamp;

    typedef struct packed {
        logic        two_digit_year;
        logic        has_offset;
        logic        offset_negative;
        logic [13:0] year;
        logic        cent_zero;
        logic [1:0]  cent_low;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  offset_hours;
        logic [5:0]  offset_minutes;
    } t_norm;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_utc;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
            MONTH_FEB: len = leap ? DAYS_FEB_LP : DAYS_FEB;
            default: len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tou_norm.sv]
// First stage: division of the year by 100, and, when an offset is given, year wrap and field saturation.
`default_nettype none

module tou_norm import tou_pkg::*; (
    input  t_stamp i_stamp,
    output t_norm  o_norm
);

    logic [13:0] year_four;
    logic [13:0] div_in;
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [13:0] rem_wide;
    logic        rem_fix;
    logic [6:0]  rem;
    logic [3:0]  month_sat;

    assign year_four = (i_stamp.year >= YEAR_MOD_FOUR) ? i_stamp.year - YEAR_MOD_FOUR
                                                       : i_stamp.year;
    assign div_in    = i_stamp.two_digit_year ? i_stamp.year : year_four;
    assign prod      = 24'(div_in) * 24'(RECIP_CENTURY);
    assign quo       = 8'(prod >> RECIP_SHIFT);
    assign rem_wide  = div_in - 14'(16'(quo) * 16'(CENTURY));
    assign rem_fix   = rem_wide >= 14'(CENTURY);
    assign rem       = rem_fix ? 7'(rem_wide - 14'(CENTURY)) : 7'(rem_wide);

    always_comb begin
        if (i_stamp.month < MONTH_JAN) begin
            month_sat = MONTH_JAN;
        end else if (i_stamp.month > MONTH_DEC) begin
            month_sat = MONTH_DEC;
        end else begin
            month_sat = i_stamp.month;
        end
    end

    always_comb begin
        o_norm.two_digit_year  = i_stamp.two_digit_year;
        o_norm.has_offset      = i_stamp.has_offset;
        o_norm.offset_negative = i_stamp.offset_negative;
        o_norm.cent_zero       = (rem == '0);
        o_norm.cent_low        = quo[1:0] + {1'b0, rem_fix};
        o_norm.day             = i_stamp.day;
        if (i_stamp.has_offset) begin
            o_norm.year           = i_stamp.two_digit_year ? 14'(rem) : year_four;
            o_norm.month          = month_sat;
            o_norm.hour           = (i_stamp.hour > HOUR_MAX) ? HOUR_MAX : i_stamp.hour;
            o_norm.minute         = (i_stamp.minute > MINUTE_MAX) ? MINUTE_MAX
                                                                  : i_stamp.minute;
            o_norm.second         = (i_stamp.second > MINUTE_MAX) ? MINUTE_MAX
                                                                  : i_stamp.second;
            o_norm.offset_hours   = (i_stamp.offset_hours > HOUR_MAX) ? HOUR_MAX
                                                                      : i_stamp.offset_hours;
            o_norm.offset_minutes = (i_stamp.offset_minutes > MINUTE_MAX)
                                    ? MINUTE_MAX : i_stamp.offset_minutes;
        end else begin
            o_norm.year           = i_stamp.year;
            o_norm.month          = i_stamp.month;
            o_norm.hour           = i_stamp.hour;
            o_norm.minute         = i_stamp.minute;
            o_norm.second         = i_stamp.second;
            o_norm.offset_hours   = i_stamp.offset_hours;
            o_norm.offset_minutes = i_stamp.offset_minutes;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tou_shift.sv]
// Second stage: leap test, day clamp, offset removal and calendar carry, applied when an offset is given.
`default_nettype none

module tou_shift import tou_pkg::*; (
    input  t_norm i_norm,
    output t_utc  o_utc
);

    logic        leap;
    logic [4:0]  len;
    logic [4:0]  prev_len;
    logic [4:0]  day_sat;
    logic [13:0] year_top;
    logic [6:0]  min_sum;
    logic        min_wrap;
    logic [5:0]  hour_sum;
    logic        hour_wrap;
    logic [6:0]  min_diff;
    logic        min_borrow;
    logic [5:0]  hour_diff;
    logic        hour_borrow;
    logic [5:0]  min_new;
    logic [4:0]  hour_new;
    logic        carry_up;
    logic        carry_down;

    always_comb begin
        if (i_norm.two_digit_year) begin
            leap = (i_norm.year[1:0] == 2'b00);
        end else begin
            leap = (i_norm.year[1:0] == 2'b00)
                   && (!i_norm.cent_zero || (i_norm.cent_low == 2'b00));
        end
    end

    assign len      = month_len(i_norm.month, leap);
    assign prev_len = month_len(i_norm.month - 4'd1, leap);
    assign year_top = i_norm.two_digit_year ? YEAR_TOP_TWO : YEAR_TOP_FOUR;

    always_comb begin
        if (i_norm.day < DAY_FIRST) begin
            day_sat = DAY_FIRST;
        end else if (i_norm.day > len) begin
            day_sat = len;
        end else begin
            day_sat = i_norm.day;
        end
    end

    // A minus offset is added to local time, a plus offset is subtracted.
    assign min_sum     = {1'b0, i_norm.minute} + {1'b0, i_norm.offset_minutes};
    assign min_wrap    = min_sum >= MIN_PER_HOUR;
    assign hour_sum    = {1'b0, i_norm.hour} + {1'b0, i_norm.offset_hours}
                         + {5'd0, min_wrap};
    assign hour_wrap   = hour_sum >= HOUR_PER_DAY;

    assign min_diff    = {1'b0, i_norm.minute} - {1'b0, i_norm.offset_minutes};
    assign min_borrow  = min_diff[6];
    assign hour_diff   = {1'b0, i_norm.hour} - {1'b0, i_norm.offset_hours}
                         - {5'd0, min_borrow};
    assign hour_borrow = hour_diff[5];

    always_comb begin
        if (i_norm.offset_negative) begin
            min_new  = min_wrap ? 6'(min_sum - MIN_PER_HOUR) : 6'(min_sum);
            hour_new = hour_wrap ? 5'(hour_sum - HOUR_PER_DAY) : 5'(hour_sum);
        end else begin
            min_new  = min_borrow ? 6'(min_diff + MIN_PER_HOUR) : 6'(min_diff);
            hour_new = hour_borrow ? 5'(hour_diff + HOUR_PER_DAY) : 5'(hour_diff);
        end
    end

    assign carry_up   = i_norm.offset_negative && hour_wrap;
    assign carry_down = !i_norm.offset_negative && hour_borrow;

    always_comb begin
        o_utc.year   = i_norm.year;
        o_utc.month  = i_norm.month;
        o_utc.day    = i_norm.day;
        o_utc.hour   = i_norm.hour;
        o_utc.minute = i_norm.minute;
        o_utc.second = i_norm.second;
        if (i_norm.has_offset) begin
            o_utc.day    = day_sat;
            o_utc.hour   = hour_new;
            o_utc.minute = min_new;
            if (carry_down) begin
                if (day_sat > DAY_FIRST) begin
                    o_utc.day = day_sat - 5'd1;
                end else if (i_norm.month > MONTH_JAN) begin
                    o_utc.month = i_norm.month - 4'd1;
                    o_utc.day   = prev_len;
                end else begin
                    o_utc.month = MONTH_DEC;
                    o_utc.day   = DAYS_LONG;
                    o_utc.year  = (i_norm.year == '0) ? year_top : i_norm.year - 14'd1;
                end
            end else if (carry_up) begin
                if (day_sat < len) begin
                    o_utc.day = day_sat + 5'd1;
                end else if (i_norm.month < MONTH_DEC) begin
                    o_utc.month = i_norm.month + 4'd1;
                    o_utc.day   = DAY_FIRST;
                end else begin
                    o_utc.month = MONTH_JAN;
                    o_utc.day   = DAY_FIRST;
                    o_utc.year  = (i_norm.year >= year_top) ? '0 : i_norm.year + 14'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/time_offset_to_utc_unit.sv]
// Top level of the time offset to UTC unit: three-register pipeline with handshakes.
//
//  Channel   Direction  Handshake                  Word
//  input     in         i_in_valid / o_in_ready    local timestamp and offset
//  output    out        o_out_valid / i_out_ready  UTC timestamp
//
// Each word passes an input register, a normalising register and a result register,
// in that order, and its result is presented from the result register.
// One word is accepted every cycle while the output side keeps taking results.
// Reset clears the three valid flags only; the payload registers are not reset.
// A stall at the output fills the pipeline, after which o_in_ready falls.
`default_nettype none

`include "time_offset_to_utc_unit_defines.svh"

module time_offset_to_utc_unit import tou_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_two_digit_year,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    input  logic        i_has_offset,
    input  logic        i_offset_negative,
    input  logic [4:0]  i_offset_hours,
    input  logic [5:0]  i_offset_minutes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [13:0] o_utc_year,
    output logic [3:0]  o_utc_month,
    output logic [4:0]  o_utc_day,
    output logic [4:0]  o_utc_hour,
    output logic [5:0]  o_utc_minute,
    output logic [5:0]  o_utc_second
);

    logic   r_in_valid;
    logic   r_a_valid;
    logic   r_out_valid;
    t_stamp r_in;
    t_norm  r_a;
    t_utc   r_out;
    t_stamp n_in;
    t_norm  n_a;
    t_utc   n_out;
    logic   out_stage_ready;
    logic   a_stage_ready;
    logic   in_stage_ready;

    assign n_in.two_digit_year  = i_two_digit_year;
    assign n_in.year            = i_year;
    assign n_in.month           = i_month;
    assign n_in.day             = i_day;
    assign n_in.hour            = i_hour;
    assign n_in.minute          = i_minute;
    assign n_in.second          = i_second;
    assign n_in.has_offset      = i_has_offset;
    assign n_in.offset_negative = i_offset_negative;
    assign n_in.offset_hours    = i_offset_hours;
    assign n_in.offset_minutes  = i_offset_minutes;

    tou_norm u_norm (
        .i_stamp (r_in),
        .o_norm  (n_a)
    );

    tou_shift u_shift (
        .i_norm (r_a),
        .o_utc  (n_out)
    );

    assign out_stage_ready = !r_out_valid || i_out_ready;
    assign a_stage_ready   = !r_a_valid || out_stage_ready;
    assign in_stage_ready  = !r_in_valid || a_stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_stage_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (a_stage_ready) begin
                r_a_valid <= r_in_valid;
            end
            if (out_stage_ready) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_stage_ready && i_in_valid) begin
            r_in <= n_in;
        end
        if (a_stage_ready && r_in_valid) begin
            r_a <= n_a;
        end
        if (out_stage_ready && r_a_valid) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready   = in_stage_ready;
    assign o_out_valid  = r_out_valid;
    assign o_utc_year   = r_out.year;
    assign o_utc_month  = r_out.month;
    assign o_utc_day    = r_out.day;
    assign o_utc_hour   = r_out.hour;
    assign o_utc_minute = r_out.minute;
    assign o_utc_second = r_out.second;

    `TOU_ASSERT_NOW(a_stall_means_full, i_clk, i_rst_n, !o_in_ready,
        r_in_valid && r_a_valid && r_out_valid)
    `TOU_ASSERT_NEXT(a_accept_fills_input, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_in_valid)
    `TOU_ASSERT_NEXT(a_middle_moves_out, i_clk, i_rst_n, r_a_valid && a_stage_ready,
        r_out_valid)
    `TOU_ASSERT_NOW(a_norm_in_range, i_clk, i_rst_n, r_a_valid && r_a.has_offset,
        (r_a.month >= MONTH_JAN) && (r_a.month <= MONTH_DEC) && (r_a.hour <= HOUR_MAX))

endmodule

`default_nettype wire
